/* hdl/csf_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// csf_pkg
// Shared types, register indexes and helpers of the case-insensitive
// substring filter.
// ----------------------------------------------------------------------------
package csf_pkg;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 64;

    localparam logic [CFG_IDX_W-1:0] CFG_NEEDLE_LEN  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHARS_LOW   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CHARS_HIGH  = 2'd2;

    localparam int NEEDLE_LEN_W     = 5;
    localparam int NEEDLE_REG_CHARS = 16;
    localparam int CHAR_W           = 8;
    localparam int NEEDLE_BITS      = NEEDLE_REG_CHARS * CHAR_W;

    // width of the reported indexes
    localparam int RES_IDX_W = 7;

    typedef struct packed {
        logic              new_search;
        logic [CHAR_W-1:0] char_code;
        logic              has_char;
        logic              last_of_entry;
    } item_t;

    typedef struct packed {
        logic                 matched;
        logic [RES_IDX_W-1:0] entry_index;
        logic [RES_IDX_W-1:0] slot_index;
    } result_t;

    // per-cycle control shared by every window cell
    typedef struct packed {
        logic shift;
        logic clear;
    } cell_ctrl_t;

    // ascii upper case to lower case, everything else unchanged
    function automatic logic [CHAR_W-1:0] fold_byte(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] r;
        r = c;
        if (c inside {[8'h41:8'h5A]})
        begin
            r = c + 8'h20;
        end
        return r;
    endfunction

endpackage
`default_nettype wire

/* hdl/csf_cell.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// csf_cell
// One byte of the search window: takes the byte of its neighbor on a shift,
// and compares the shifted value with its aligned needle character.
// ----------------------------------------------------------------------------
module csf_cell (
    input  logic                            clk,
    input  logic                            rst_n,
    input  csf_pkg::cell_ctrl_t             ctrl,
    input  logic [csf_pkg::CHAR_W-1:0]      din,
    input  logic [csf_pkg::CHAR_W-1:0]      ref_char,
    input  logic                            cmp_en,
    output logic [csf_pkg::CHAR_W-1:0]      dout,
    output logic                            eq
);

    logic [csf_pkg::CHAR_W-1:0] win_reg;
    logic [csf_pkg::CHAR_W-1:0] win_next;
    logic [csf_pkg::CHAR_W-1:0] shifted;

    always_comb
    begin
        shifted = ctrl.shift ? din : win_reg;
        // positions beyond the needle length always agree
        eq      = !cmp_en || (shifted == ref_char);
        if (ctrl.clear)
        begin
            win_next = '0;
        end
        else
        begin
            win_next = shifted;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg <= '0;
        end
        else
        begin
            win_reg <= win_next;
        end
    end

    assign dout = win_reg;

endmodule
`default_nettype wire

/* hdl/case_insensitive_substring_filter_top.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// case_insensitive_substring_filter_top
// Streams name entries one byte per transaction and reports, per entry,
// whether it contains the configured needle regardless of ascii case.
// ----------------------------------------------------------------------------
// The block takes one entry byte per clock: an item transaction is accepted
// in every cycle unless both result slots are full. Bytes are folded to lower
// case and shifted through a row of NEEDLE_MAX window cells; each cell
// compares its new byte with the needle character aligned to its position, so
// the whole window check finishes in the same cycle as the byte arrives. The
// last item of an entry produces one registered result transaction
// (matched, entry index, compacted slot). Results go through an output
// register backed by a skid register, so item_stall rises only when two
// results are waiting; with result_stall low the block never stalls. The
// needle may be up to 16 characters (needle_len zero matches every entry,
// even an empty one); an entry shorter than the needle never matches. Entry
// and slot counters hold at ENTRY_MAX - 1 and restart when an item carries
// new_search. Configuration writes apply to the next accepted byte. There is
// no clearing pass after reset.
// ----------------------------------------------------------------------------
module case_insensitive_substring_filter_top #(
    parameter int NEEDLE_MAX = 16,
    parameter int ENTRY_MAX  = 128
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration write port
    input  logic                                cfg_we,
    input  logic [csf_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [csf_pkg::CFG_DATA_W-1:0]      cfg_data,
    // entry bytes
    input  logic                                item_valid,
    output logic                                item_stall,
    input  csf_pkg::item_t                      item,
    // per-entry results
    output logic                                result_valid,
    input  logic                                result_stall,
    output csf_pkg::result_t                    result
);

    localparam int SEEN_W = $clog2(NEEDLE_MAX + 1);
    localparam int CW     = (SEEN_W > csf_pkg::NEEDLE_LEN_W) ? SEEN_W : csf_pkg::NEEDLE_LEN_W;
    localparam int CNT_W  = $clog2(ENTRY_MAX);
    localparam int CH     = csf_pkg::CHAR_W;
    localparam int WIN_W  = NEEDLE_MAX * CH;
    localparam int RW     = csf_pkg::RES_IDX_W;

    // configuration registers
    logic [csf_pkg::NEEDLE_LEN_W-1:0] needle_len_reg;
    logic [csf_pkg::NEEDLE_BITS-1:0]  needle_chars_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            needle_len_reg   <= '0;
            needle_chars_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                csf_pkg::CFG_NEEDLE_LEN:
                begin
                    needle_len_reg <= cfg_data[csf_pkg::NEEDLE_LEN_W-1:0];
                end
                csf_pkg::CFG_CHARS_LOW:
                begin
                    needle_chars_reg[csf_pkg::CFG_DATA_W-1:0] <= cfg_data;
                end
                csf_pkg::CFG_CHARS_HIGH:
                begin
                    needle_chars_reg[csf_pkg::NEEDLE_BITS-1:csf_pkg::CFG_DATA_W] <= cfg_data;
                end
                default:
                begin
                end
            endcase
        end
    end

    // active needle length, clamped to the window depth
    logic [CW-1:0] len_ext;
    logic [CW-1:0] active_len;
    logic [CW-1:0] align_amt;
    logic          len_zero;

    assign len_ext    = CW'(needle_len_reg);
    assign active_len = (len_ext > CW'(NEEDLE_MAX)) ? CW'(NEEDLE_MAX) : len_ext;
    assign align_amt  = CW'(NEEDLE_MAX) - active_len;
    assign len_zero   = (active_len == '0);

    // folded needle, reversed: byte j holds needle character NEEDLE_MAX-1-j;
    // characters past the register set read as zero
    logic [WIN_W-1:0] needle_rev;
    logic [WIN_W-1:0] needle_aligned;

    for (genvar k = 0; k < NEEDLE_MAX; k++)
    begin : g_needle
        if (k < csf_pkg::NEEDLE_REG_CHARS)
        begin : g_reg
            assign needle_rev[(NEEDLE_MAX-1-k)*CH +: CH] =
                csf_pkg::fold_byte(needle_chars_reg[k*CH +: CH]);
        end
        else
        begin : g_zero
            assign needle_rev[(NEEDLE_MAX-1-k)*CH +: CH] = '0;
        end
    end

    // window position p meets needle character len-1-p
    assign needle_aligned = needle_rev >> {align_amt, 3'b000};

    // handshake
    logic item_fire;
    assign item_fire = item_valid && !item_stall;

    csf_pkg::cell_ctrl_t cell_ctrl;
    assign cell_ctrl.shift = item_fire && item.has_char;
    assign cell_ctrl.clear = item_fire && item.last_of_entry;

    // window cell row, position 0 holds the newest byte
    logic [NEEDLE_MAX-1:0][CH-1:0] win;
    logic [NEEDLE_MAX-1:0]         cell_eq;

    for (genvar p = 0; p < NEEDLE_MAX; p++)
    begin : g_cell
        logic [CH-1:0] cell_din;
        if (p == 0)
        begin : g_head
            assign cell_din = csf_pkg::fold_byte(item.char_code);
        end
        else
        begin : g_body
            assign cell_din = win[p-1];
        end

        csf_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctrl     (cell_ctrl),
            .din      (cell_din),
            .ref_char (needle_aligned[p*CH +: CH]),
            .cmp_en   (CW'(p) < active_len),
            .dout     (win[p]),
            .eq       (cell_eq[p])
        );
    end

    // per-entry match tracking
    logic [SEEN_W-1:0] seen_reg;
    logic [SEEN_W-1:0] seen_next;
    logic [SEEN_W-1:0] seen_inc;
    logic              found_reg;
    logic              found_next;
    logic              found_now;
    logic              hit_byte;
    logic              hit;

    assign seen_inc  = (seen_reg == SEEN_W'(NEEDLE_MAX)) ? seen_reg : seen_reg + 1'b1;
    // enough bytes seen and every active cell agrees
    assign hit_byte  = item.has_char &&
                       (len_zero || ((CW'(seen_inc) >= active_len) && (&cell_eq)));
    assign found_now = found_reg || hit_byte;
    assign hit       = found_now || len_zero;

    always_comb
    begin
        seen_next  = seen_reg;
        found_next = found_reg;
        if (item_fire)
        begin
            if (item.last_of_entry)
            begin
                seen_next  = '0;
                found_next = 1'b0;
            end
            else if (item.has_char)
            begin
                seen_next  = seen_inc;
                found_next = found_now;
            end
        end
    end

    // entry and slot counters, saturating, restarted by new_search
    logic [CNT_W-1:0] entry_cnt_reg;
    logic [CNT_W-1:0] entry_cnt_next;
    logic [CNT_W-1:0] slot_cnt_reg;
    logic [CNT_W-1:0] slot_cnt_next;
    logic [CNT_W-1:0] entry_base;
    logic [CNT_W-1:0] slot_base;
    logic [CNT_W+RW-1:0] entry_ext;
    logic [CNT_W+RW-1:0] slot_ext;

    assign entry_base = item.new_search ? '0 : entry_cnt_reg;
    assign slot_base  = item.new_search ? '0 : slot_cnt_reg;
    assign entry_ext  = {{RW{1'b0}}, entry_base};
    assign slot_ext   = {{RW{1'b0}}, slot_base};

    always_comb
    begin
        entry_cnt_next = entry_cnt_reg;
        slot_cnt_next  = slot_cnt_reg;
        if (item_fire)
        begin
            entry_cnt_next = entry_base;
            slot_cnt_next  = slot_base;
            if (item.last_of_entry)
            begin
                if (entry_base != CNT_W'(ENTRY_MAX - 1))
                begin
                    entry_cnt_next = entry_base + 1'b1;
                end
                if (hit && (slot_base != CNT_W'(ENTRY_MAX - 1)))
                begin
                    slot_cnt_next = slot_base + 1'b1;
                end
            end
        end
    end

    // result of the entry that ends with this byte
    csf_pkg::result_t res_now;
    always_comb
    begin
        res_now.matched     = hit;
        res_now.entry_index = entry_ext[RW-1:0];
        res_now.slot_index  = hit ? slot_ext[RW-1:0] : '0;
    end

    // output register with skid register behind it
    logic             out_valid_reg;
    logic             out_valid_next;
    logic             skid_valid_reg;
    logic             skid_valid_next;
    csf_pkg::result_t out_reg;
    csf_pkg::result_t out_next;
    csf_pkg::result_t skid_reg;
    csf_pkg::result_t skid_next;
    logic             out_fire;
    logic             res_push;

    assign out_fire = out_valid_reg && !result_stall;
    assign res_push = item_fire && item.last_of_entry;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_next        = out_reg;
        skid_next       = skid_reg;
        if (skid_valid_reg)
        begin
            // no new transaction while the skid register is full
            if (out_fire)
            begin
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (res_push)
        begin
            if (!out_valid_reg || out_fire)
            begin
                out_next       = res_now;
                out_valid_next = 1'b1;
            end
            else
            begin
                skid_next       = res_now;
                skid_valid_next = 1'b1;
            end
        end
        else if (out_fire)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg       <= '0;
            found_reg      <= 1'b0;
            entry_cnt_reg  <= '0;
            slot_cnt_reg   <= '0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            seen_reg       <= seen_next;
            found_reg      <= found_next;
            entry_cnt_reg  <= entry_cnt_next;
            slot_cnt_reg   <= slot_cnt_next;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign item_stall   = skid_valid_reg;
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule
`default_nettype wire

/* hdl/csf_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// csf_checker
// Port-level checks of the substring filter, bound to the top level.
// ----------------------------------------------------------------------------
module csf_checker #(
    parameter int ENTRY_MAX = 128
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_stall,
    input  logic             result_valid,
    input  logic             result_stall,
    input  csf_pkg::result_t result
);

    // a stalled result transaction holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("result changed while stalled");

    // a non-matching entry reports slot zero
    a_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.matched |-> result.slot_index == '0)
        else $error("slot index set on a miss");

    // slots are compacted, never ahead of the entry index
    a_slot_order: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.matched |->
            (ENTRY_MAX > 128) || (result.slot_index <= result.entry_index))
        else $error("slot index beyond entry index");

    // input backpressure only with a result waiting
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !result_valid |-> !item_stall)
        else $error("item stall with empty output");

endmodule

bind case_insensitive_substring_filter_top csf_checker #(
    .ENTRY_MAX (ENTRY_MAX)
) u_csf_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_stall   (item_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);
`default_nettype wire
